FILE: rtl/pgsu_pkg.sv
// ----------------------------------------------------------------------------
// pgsu_pkg: shared constants, codes, types and tables
// Operation codes, register indexes, reset values, the controller to
// datapath command and status structs, and the exp2 fraction table.
// ----------------------------------------------------------------------------
`default_nettype none

package pgsu_pkg;

    localparam int MAX_SITES_DEF   = 32;
    localparam int MAX_STATES_DEF  = 8;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam logic [1:0] OP_FIELD    = 2'd0;
    localparam logic [1:0] OP_COUPLING = 2'd1;
    localparam logic [1:0] OP_SET      = 2'd2;
    localparam logic [1:0] OP_RESAMPLE = 2'd3;

    localparam logic CFG_SITE_COUNT  = 1'b0;
    localparam logic CFG_STATE_COUNT = 1'b1;

    localparam logic [5:0] SITE_COUNT_RESET  = 6'd32;
    localparam logic [3:0] STATE_COUNT_RESET = 4'd2;

    // log2(e) in Q16
    localparam logic [31:0] LOG2E_Q16 = 32'd94548;

    typedef struct packed {
        logic accept;     // input beat taken this cycle
        logic f_rd;       // read field weight for current state
        logic c_rd;       // read coupling for current neighbor
        logic c_last;     // last neighbor of current state
        logic x_issue;    // push one state into the exp pipeline
        logic prod;       // form u * total
        logic pick_step;  // test one cumulative weight
        logic commit;     // write back and load the result
    } cmd_t;

    typedef struct packed {
        logic go;         // accepted beat is a resample of a site in use
        logic hit;        // cumulative weight passes the threshold
    } status_t;

    // round(65536 * 2^(-i/32))
    function automatic logic [16:0] exp2_frac(input logic [5:0] i);
        logic [16:0] v;
        unique case (i)
            6'd0:  v = 17'd65536;
            6'd1:  v = 17'd64132;
            6'd2:  v = 17'd62757;
            6'd3:  v = 17'd61413;
            6'd4:  v = 17'd60097;
            6'd5:  v = 17'd58809;
            6'd6:  v = 17'd57549;
            6'd7:  v = 17'd56316;
            6'd8:  v = 17'd55109;
            6'd9:  v = 17'd53928;
            6'd10: v = 17'd52773;
            6'd11: v = 17'd51642;
            6'd12: v = 17'd50535;
            6'd13: v = 17'd49452;
            6'd14: v = 17'd48393;
            6'd15: v = 17'd47356;
            6'd16: v = 17'd46341;
            6'd17: v = 17'd45348;
            6'd18: v = 17'd44376;
            6'd19: v = 17'd43425;
            6'd20: v = 17'd42495;
            6'd21: v = 17'd41584;
            6'd22: v = 17'd40693;
            6'd23: v = 17'd39821;
            6'd24: v = 17'd38968;
            6'd25: v = 17'd38133;
            6'd26: v = 17'd37316;
            6'd27: v = 17'd36516;
            6'd28: v = 17'd35734;
            6'd29: v = 17'd34968;
            6'd30: v = 17'd34219;
            6'd31: v = 17'd33486;
            6'd32: v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/potts_gibbs_site_update.sv
// ----------------------------------------------------------------------------
// potts_gibbs_site_update: Potts model Gibbs sampler, one site per request
// Top level joining the resample sequencer and the datapath.
// ----------------------------------------------------------------------------
// Weight writes and site state writes give no result. A resample of
// site i reads, for each state from 1 to S-1, one field weight and then
// one coupling word for each of the N sites in use, takes the exponential
// of all S states, forms u * total and then tests cumulative weights, up
// to S-1 of them, until the draw is decided. The single read port of the
// coupling memory, one coupling word a cycle, dominates the resample time.
// A result waits in an output register while further write beats are
// taken. The weight memories come up with undefined contents and need no
// clearing pass.
`default_nettype none

module potts_gibbs_site_update #(
    parameter int MAX_SITES   = pgsu_pkg::MAX_SITES_DEF,
    parameter int MAX_STATES  = pgsu_pkg::MAX_STATES_DEF,
    parameter int WEIGHT_BITS = pgsu_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [5:0]                    cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    operation,
    input  wire logic [4:0]                    site,
    input  wire logic [4:0]                    partner_site,
    input  wire logic [2:0]                    state_a,
    input  wire logic [2:0]                    state_b,
    input  wire logic signed [WEIGHT_BITS-1:0] weight,
    input  wire logic [15:0]                   random_u,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [4:0]                         site_out,
    output logic [2:0]                         new_state
);

    pgsu_pkg::cmd_t                    cmd;
    pgsu_pkg::status_t                 status;
    logic [$clog2(MAX_STATES)-1:0]     s_idx;
    logic [$clog2(MAX_SITES)-1:0]      k_idx;
    logic [$clog2(MAX_SITES+1)-1:0]    n_sites;
    logic [$clog2(MAX_STATES+1)-1:0]   n_states;

    pgsu_ctrl #(
        .MAX_SITES  (MAX_SITES),
        .MAX_STATES (MAX_STATES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .n_sites   (n_sites),
        .n_states  (n_states),
        .status    (status),
        .cmd       (cmd),
        .s_idx     (s_idx),
        .k_idx     (k_idx)
    );

    pgsu_datapath #(
        .MAX_SITES   (MAX_SITES),
        .MAX_STATES  (MAX_STATES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .site         (site),
        .partner_site (partner_site),
        .state_a      (state_a),
        .state_b      (state_b),
        .weight       (weight),
        .random_u     (random_u),
        .cmd          (cmd),
        .s_idx        (s_idx),
        .k_idx        (k_idx),
        .n_sites      (n_sites),
        .n_states     (n_states),
        .status       (status),
        .site_out     (site_out),
        .new_state    (new_state)
    );

endmodule

`default_nettype wire

FILE: rtl/pgsu_ctrl.sv
// ----------------------------------------------------------------------------
// pgsu_ctrl: resample sequencer
// Steps a resample through energy accumulation, exponentials, the
// normalizing product, the cumulative search and the write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module pgsu_ctrl #(
    parameter int MAX_SITES  = pgsu_pkg::MAX_SITES_DEF,
    parameter int MAX_STATES = pgsu_pkg::MAX_STATES_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    input  wire logic [$clog2(MAX_SITES+1)-1:0]       n_sites,
    input  wire logic [$clog2(MAX_STATES+1)-1:0]      n_states,
    input  wire pgsu_pkg::status_t                    status,
    output pgsu_pkg::cmd_t                            cmd,
    output logic [$clog2(MAX_STATES)-1:0]             s_idx,
    output logic [$clog2(MAX_SITES)-1:0]              k_idx
);

    localparam int SAW = $clog2(MAX_SITES);
    localparam int STW = $clog2(MAX_STATES);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIELD,
        ST_COUPLE,
        ST_EDRAIN,
        ST_EXP,
        ST_XDRAIN,
        ST_PROD,
        ST_PICK,
        ST_COMMIT
    } state_t;

    state_t           state_reg;
    logic [STW-1:0]   s_reg;
    logic [SAW-1:0]   k_reg;
    logic             out_valid_reg;
    logic             k_last;
    logic             s_last;
    logic             s_pick_last;

    assign k_last      = int'(k_reg) == int'(n_sites) - 1;
    assign s_last      = int'(s_reg) == int'(n_states) - 1;
    assign s_pick_last = int'(s_reg) == int'(n_states) - 2;

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;
    assign s_idx     = s_reg;
    assign k_idx     = k_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.accept    = in_valid && in_ready;
        cmd.f_rd      = state_reg == ST_FIELD;
        cmd.c_rd      = state_reg == ST_COUPLE;
        cmd.c_last    = state_reg == ST_COUPLE && k_last;
        cmd.x_issue   = state_reg == ST_EXP;
        cmd.prod      = state_reg == ST_PROD;
        cmd.pick_step = state_reg == ST_PICK;
        cmd.commit    = state_reg == ST_COMMIT && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.accept && status.go)
                    begin
                        s_reg     <= STW'(1);
                        state_reg <= ST_FIELD;
                    end
                end
                ST_FIELD:
                begin
                    k_reg     <= '0;
                    state_reg <= ST_COUPLE;
                end
                ST_COUPLE:
                begin
                    if (k_last)
                    begin
                        if (s_last)
                        begin
                            state_reg <= ST_EDRAIN;
                        end
                        else
                        begin
                            s_reg     <= s_reg + STW'(1);
                            state_reg <= ST_FIELD;
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + SAW'(1);
                    end
                end
                ST_EDRAIN:
                begin
                    s_reg     <= '0;
                    state_reg <= ST_EXP;
                end
                ST_EXP:
                begin
                    if (s_last)
                    begin
                        state_reg <= ST_XDRAIN;
                    end
                    else
                    begin
                        s_reg <= s_reg + STW'(1);
                    end
                end
                ST_XDRAIN:
                begin
                    state_reg <= ST_PROD;
                end
                ST_PROD:
                begin
                    s_reg     <= '0;
                    state_reg <= ST_PICK;
                end
                ST_PICK:
                begin
                    if (status.hit || s_pick_last)
                    begin
                        state_reg <= ST_COMMIT;
                    end
                    else
                    begin
                        s_reg <= s_reg + STW'(1);
                    end
                end
                ST_COMMIT:
                begin
                    if (cmd.commit)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pgsu_datapath.sv
// ----------------------------------------------------------------------------
// pgsu_datapath: weight stores, energy accumulator and sampling arithmetic
// Holds configuration, site states, field and coupling memories, the
// energy and weight registers, the exp pipeline and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pgsu_datapath #(
    parameter int MAX_SITES   = pgsu_pkg::MAX_SITES_DEF,
    parameter int MAX_STATES  = pgsu_pkg::MAX_STATES_DEF,
    parameter int WEIGHT_BITS = pgsu_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic                                 cfg_index,
    input  wire logic [5:0]                           cfg_data,
    input  wire logic [1:0]                           operation,
    input  wire logic [4:0]                           site,
    input  wire logic [4:0]                           partner_site,
    input  wire logic [2:0]                           state_a,
    input  wire logic [2:0]                           state_b,
    input  wire logic signed [WEIGHT_BITS-1:0]        weight,
    input  wire logic [15:0]                          random_u,
    input  wire pgsu_pkg::cmd_t                       cmd,
    input  wire logic [$clog2(MAX_STATES)-1:0]        s_idx,
    input  wire logic [$clog2(MAX_SITES)-1:0]         k_idx,
    output logic [$clog2(MAX_SITES+1)-1:0]            n_sites,
    output logic [$clog2(MAX_STATES+1)-1:0]           n_states,
    output pgsu_pkg::status_t                         status,
    output logic [4:0]                                site_out,
    output logic [2:0]                                new_state
);

    localparam int NW     = MAX_STATES - 1;
    localparam int SAW    = $clog2(MAX_SITES);
    localparam int STW    = $clog2(MAX_STATES);
    localparam int NSW    = $clog2(MAX_SITES + 1);
    localparam int NSTW   = $clog2(MAX_STATES + 1);
    localparam int FDEPTH = MAX_SITES * NW;
    localparam int FAW    = $clog2(FDEPTH);
    localparam int CDEPTH = MAX_SITES * MAX_SITES * NW * NW;
    localparam int CAW    = $clog2(CDEPTH);
    localparam int EW     = WEIGHT_BITS + $clog2(MAX_SITES) + 1;
    localparam int TW     = 17 + STW;
    localparam int PW     = TW + 16;

    // configuration
    logic [5:0] site_count_reg;
    logic [3:0] state_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_count_reg  <= pgsu_pkg::SITE_COUNT_RESET;
            state_count_reg <= pgsu_pkg::STATE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pgsu_pkg::CFG_SITE_COUNT:  site_count_reg  <= cfg_data;
                pgsu_pkg::CFG_STATE_COUNT: state_count_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        int sc;
        int stc;
        sc  = int'(site_count_reg);
        stc = int'(state_count_reg);
        if (sc < 1)
            sc = 1;
        if (sc > MAX_SITES)
            sc = MAX_SITES;
        if (stc < 2)
            stc = 2;
        if (stc > MAX_STATES)
            stc = MAX_STATES;
        n_sites  = NSW'(sc);
        n_states = NSTW'(stc);
    end

    // write decode at the input beat
    logic           fw_ok;
    logic           cw_ok;
    logic           set_ok;
    logic [FAW-1:0] fw_addr;
    logic [CAW-1:0] cw_addr;

    assign fw_ok = int'(site) < MAX_SITES && state_a != 3'd0 && int'(state_a) < MAX_STATES;
    assign cw_ok = site < partner_site && int'(partner_site) < MAX_SITES
                   && state_a != 3'd0 && int'(state_a) < MAX_STATES
                   && state_b != 3'd0 && int'(state_b) < MAX_STATES;
    assign set_ok = int'(site) < MAX_SITES && int'(state_a) < int'(n_states);
    assign fw_addr = FAW'(int'(site) * NW + int'(state_a) - 1);
    assign cw_addr = CAW'(((int'(site) * MAX_SITES + int'(partner_site)) * NW
                           + int'(state_a) - 1) * NW + int'(state_b) - 1);

    assign status.go = operation == pgsu_pkg::OP_RESAMPLE && int'(site) < int'(n_sites);

    // latched resample item
    logic [4:0]  site_q_reg;
    logic [15:0] u_q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            site_q_reg <= site;
            u_q_reg    <= random_u;
        end
    end

    // site states and result
    logic [STW-1:0] site_states_reg [MAX_SITES];
    logic [STW-1:0] pick_reg;
    logic [4:0]     site_out_reg;
    logic [2:0]     new_state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SITES; i++)
            begin
                site_states_reg[i] <= '0;
            end
        end
        else if (cmd.accept && operation == pgsu_pkg::OP_SET && set_ok)
        begin
            site_states_reg[SAW'(site)] <= STW'(state_a);
        end
        else if (cmd.commit)
        begin
            site_states_reg[SAW'(site_q_reg)] <= pick_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            site_out_reg  <= site_q_reg;
            new_state_reg <= 3'(pick_reg);
        end
    end

    assign site_out  = site_out_reg;
    assign new_state = new_state_reg;

    // weight memories
    logic signed [WEIGHT_BITS-1:0] field_mem [FDEPTH];
    logic signed [WEIGHT_BITS-1:0] coup_mem [CDEPTH];
    logic signed [WEIGHT_BITS-1:0] fdata_reg;
    logic signed [WEIGHT_BITS-1:0] cdata_reg;
    logic [FAW-1:0]                fr_addr;
    logic [CAW-1:0]                cr_addr;
    logic [STW-1:0]                nb_state;
    logic                          nb_ok;

    assign fr_addr  = FAW'(int'(site_q_reg) * NW + int'(s_idx) - 1);
    assign nb_state = site_states_reg[k_idx];
    // a neighbor beyond the state count counts as state zero
    assign nb_ok    = k_idx != SAW'(site_q_reg) && nb_state != '0
                      && int'(nb_state) < int'(n_states);

    always_comb
    begin
        if (int'(site_q_reg) < int'(k_idx))
            cr_addr = CAW'(((int'(site_q_reg) * MAX_SITES + int'(k_idx)) * NW
                            + int'(s_idx) - 1) * NW + int'(nb_state) - 1);
        else
            cr_addr = CAW'(((int'(k_idx) * MAX_SITES + int'(site_q_reg)) * NW
                            + int'(nb_state) - 1) * NW + int'(s_idx) - 1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && operation == pgsu_pkg::OP_FIELD && fw_ok)
        begin
            field_mem[fw_addr] <= weight;
        end
        if (cmd.f_rd)
        begin
            fdata_reg <= field_mem[fr_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && operation == pgsu_pkg::OP_COUPLING && cw_ok)
        begin
            coup_mem[cw_addr] <= weight;
        end
        if (cmd.c_rd)
        begin
            cdata_reg <= coup_mem[cr_addr];
        end
    end

    // energy accumulation, one memory word a cycle
    logic                 load_p_reg;
    logic                 add_p_reg;
    logic                 last_p_reg;
    logic [STW-1:0]       s_p_reg;
    logic signed [EW-1:0] acc_reg;
    logic signed [EW-1:0] acc_next;
    logic signed [EW-1:0] e_reg [MAX_STATES];
    logic signed [EW-1:0] m_reg;

    always_comb
    begin
        if (load_p_reg)
            acc_next = EW'(fdata_reg);
        else if (add_p_reg)
            acc_next = acc_reg + EW'(cdata_reg);
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_p_reg <= 1'b0;
            add_p_reg  <= 1'b0;
            last_p_reg <= 1'b0;
        end
        else
        begin
            load_p_reg <= cmd.f_rd;
            add_p_reg  <= cmd.c_rd && nb_ok;
            last_p_reg <= cmd.c_last;
        end
    end

    always_ff @(posedge clk)
    begin
        s_p_reg <= s_idx;
        acc_reg <= acc_next;
        if (cmd.accept)
        begin
            m_reg <= '0;
        end
        else if (last_p_reg)
        begin
            e_reg[s_p_reg] <= acc_next;
            if (acc_next > m_reg)
                m_reg <= acc_next;
        end
    end

    // exp pipeline: stage one scales by log2(e), stage two interpolates
    logic signed [EW:0]   d_val;
    logic signed [EW-1:0] e_sel;
    logic                 big_c;
    logic [15:0]          t_c;
    logic                 xv1_reg;
    logic [STW-1:0]       xs1_reg;
    logic                 big1_reg;
    logic [15:0]          t1_reg;

    assign e_sel = (s_idx == '0) ? '0 : e_reg[s_idx];
    assign d_val = (EW + 1)'(m_reg) - (EW + 1)'(e_sel);

    always_comb
    begin
        longint      dl;
        logic [13:0] dsm;
        dl    = longint'(d_val);
        // any difference this large already underflows to zero weight
        big_c = dl > 64'sd16383;
        dsm   = 14'(dl);
        t_c   = 16'((32'(dsm) * pgsu_pkg::LOG2E_Q16 + 32'd32768) >> 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            xv1_reg <= 1'b0;
        else
            xv1_reg <= cmd.x_issue;
    end

    always_ff @(posedge clk)
    begin
        xs1_reg  <= s_idx;
        big1_reg <= big_c;
        t1_reg   <= t_c;
    end

    logic [16:0]   w_c;
    logic [16:0]   w_reg [MAX_STATES];
    logic [TW-1:0] total_reg;

    always_comb
    begin
        logic [5:0]  n;
        logic [5:0]  i;
        logic [16:0] ti;
        logic [16:0] ti1;
        logic [31:0] corr;
        logic [16:0] v;
        n    = 6'(t1_reg[15:10]);
        i    = {1'b0, t1_reg[9:5]};
        ti   = pgsu_pkg::exp2_frac(i);
        ti1  = pgsu_pkg::exp2_frac(i + 6'd1);
        corr = (32'(ti - ti1) * 32'(t1_reg[4:0]) + 32'd16) >> 5;
        v    = ti - 17'(corr);
        if (big1_reg || n >= 6'd17)
            w_c = '0;
        else
            w_c = v >> n;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            total_reg <= '0;
        end
        else if (xv1_reg)
        begin
            w_reg[xs1_reg] <= w_c;
            total_reg      <= total_reg + TW'(w_c);
        end
    end

    // threshold u * total, then cumulative search
    logic [PW-1:0]  p_reg;
    logic [TW-1:0]  cum_reg;
    logic [TW-1:0]  cum_next;

    assign cum_next   = cum_reg + TW'(w_reg[s_idx]);
    assign status.hit = p_reg < {cum_next, 16'd0};

    always_ff @(posedge clk)
    begin
        if (cmd.prod)
        begin
            p_reg   <= PW'(u_q_reg) * PW'(total_reg);
            cum_reg <= '0;
        end
        else if (cmd.pick_step)
        begin
            cum_reg  <= cum_next;
            pick_reg <= status.hit ? s_idx : STW'(int'(n_states) - 1);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pgsu_checker.sv
// ----------------------------------------------------------------------------
// pgsu_checker: port-level checks for the site update block
// Watches the input and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pgsu_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [1:0] operation,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [4:0] site_out,
    input wire logic [2:0] new_state
);

    // no result is shown while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // a new result only follows a busy cycle
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a resample in flight");

    // write beats never stall the input side
    a_write_keeps_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && operation != pgsu_pkg::OP_RESAMPLE) |=> in_ready)
        else $error("write beat stalled the input");

    // hold a stalled result beat
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(site_out) && $stable(new_state)))
        else $error("stalled result changed");

endmodule

bind potts_gibbs_site_update pgsu_checker u_pgsu_checker (.*);

`default_nettype wire
